// ===== rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
package spq_pkg;
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_BITS_DEF  = 16;
  localparam int PRIO_BITS_DEF = 16;

  typedef enum logic [3:0] {
    ACT_INSERT    = 4'd0,
    ACT_POP       = 4'd1,
    ACT_REMOVE    = 4'd2,
    ACT_CHANGE    = 4'd3,
    ACT_CONTAINS  = 4'd4,
    ACT_SIZE      = 4'd5,
    ACT_FIRST     = 4'd6,
    ACT_NEXT      = 4'd7,
    ACT_CLEAR     = 4'd8
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // datapath operation selected by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE_MATCH,
    OP_DELETE_TOP,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic   load;      // capture request fields
    logic   exec;      // apply op to the entry array
    dp_op_t op;
    logic   use_new;   // insert with new priority
    logic   match_prio; // match also on priority
  } dp_cmd_t;

  typedef struct packed {
    logic key_hit;     // some entry matches key
    logic both_hit;    // some entry matches key and priority
    logic is_full;
    logic is_empty;
  } dp_stat_t;
endpackage

// ===== rtl/spq_if.sv =====
// valid/ready channel interfaces for request and response
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [15:0] key;
  logic [15:0] priority_req;
  logic [15:0] prio_update;
  modport source (output valid, action, key, priority_req, prio_update, input ready);
  modport sink (input valid, action, key, priority_req, prio_update, output ready);
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [15:0] key_out;
  logic [4:0]  count;
  modport source (output valid, status, found, key_out, count, input ready);
  modport sink (input valid, status, found, key_out, count, output ready);
endinterface

// ===== rtl/spq_datapath.sv =====
// entry array with parallel compare and shift
module spq_datapath #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spq_pkg::dp_cmd_t      cmd,
  input  logic [KEY_BITS-1:0]   key_in,
  input  logic [PRIO_BITS-1:0]  prio_in,
  input  logic [PRIO_BITS-1:0]  new_prio_in,
  input  logic [IW-1:0]         rd_idx,
  output spq_pkg::dp_stat_t     stat,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [CW-1:0]         fill
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0]  keys  [CAPACITY];
  logic [PRIO_BITS-1:0] prios [CAPACITY];
  logic [KEY_BITS-1:0]  k_r;
  logic [PRIO_BITS-1:0] p_r, np_r;
  logic [CAPACITY-1:0]  live, khit, bhit, first_hit, after_hit, ge, ins_after;
  logic [PRIO_BITS-1:0] ins_p;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r  <= key_in;
      p_r  <= prio_in;
      np_r <= new_prio_in;
    end
  end

  assign ins_p = cmd.use_new ? np_r : p_r;

  // per-entry compares
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = (CW'(i) < fill);
      khit[i] = live[i] && (keys[i] == k_r);
      bhit[i] = khit[i] && (prios[i] == p_r);
      ge[i]   = live[i] && (prios[i] >= ins_p);
    end
  end

  // one-hot first match and "at or after it" mask as a prefix scan
  always_comb begin
    logic seen;
    logic [CAPACITY-1:0] m;
    seen = 1'b0;
    m = cmd.match_prio ? bhit : khit;
    if (cmd.op == OP_DELETE_TOP) m = {{(CAPACITY-1){1'b0}}, live[0]};
    for (int i = 0; i < CAPACITY; i++) begin
      first_hit[i] = m[i] && !seen;
      seen = seen | m[i];
      after_hit[i] = seen;
    end
  end

  // entries with priority >= new stay ahead; ge is a prefix since list is sorted
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) ins_after[i] = !ge[i];
  end

  assign stat.key_hit  = |khit;
  assign stat.both_hit = |bhit;
  assign stat.is_full  = (fill == CW'(CAPACITY));
  assign stat.is_empty = (fill == '0);
  assign rd_key = keys[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        case (cmd.op)
          OP_INSERT: begin
            if (ins_after[i]) begin
              if (i == 0 || !ins_after[(i > 0) ? i - 1 : 0]) begin
                keys[i]  <= k_r;
                prios[i] <= ins_p;
              end else begin
                keys[i]  <= keys[(i > 0) ? i - 1 : 0];
                prios[i] <= prios[(i > 0) ? i - 1 : 0];
              end
            end
          end
          OP_DELETE_MATCH, OP_DELETE_TOP: begin
            if (after_hit[i] && i + 1 < CAPACITY) begin
              keys[i]  <= keys[(i + 1 < CAPACITY) ? i + 1 : i];
              prios[i] <= prios[(i + 1 < CAPACITY) ? i + 1 : i];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      case (cmd.op)
        OP_INSERT:       fill <= fill + CW'(1);
        OP_DELETE_MATCH,
        OP_DELETE_TOP:   if (|first_hit) fill <= fill - CW'(1);
        OP_CLEAR:        fill <= '0;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/spq_ctrl.sv =====
// controller: decodes actions, sequences datapath ops, forms the response
module spq_ctrl #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                clk,
  input  logic                rst,
  spq_req_if.sink             req,
  spq_rsp_if.source           rsp,
  output spq_pkg::dp_cmd_t    cmd,
  input  spq_pkg::dp_stat_t   stat,
  output logic [IW-1:0]       rd_idx,
  input  logic [KEY_BITS-1:0] rd_key,
  input  logic [CW-1:0]       fill
);
  import spq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_REINS, S_RESP} state_t;
  state_t state;
  logic [3:0] act;
  logic [IW-1:0] iter_pos;
  logic iter_valid;
  logic [1:0] status;
  logic found;
  logic rsp_valid;

  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.status = status;
  assign rsp.found = found;
  assign rsp.count = 5'(fill);
  assign rd_idx = (act == ACT_FIRST) ? '0 : iter_pos + IW'(1);

  logic [KEY_BITS-1:0] kout;
  assign rsp.key_out = 16'(kout);

  always_comb begin
    cmd = '0;
    cmd.load = req.valid && req.ready;
    cmd.op = OP_NONE;
    if (state == S_EXEC) begin
      case (act)
        ACT_INSERT: begin
          cmd.op = OP_INSERT;
          cmd.exec = !stat.is_full;
        end
        ACT_POP: begin
          cmd.op = OP_DELETE_TOP;
          cmd.exec = 1'b1;
        end
        ACT_REMOVE: begin
          cmd.op = OP_DELETE_MATCH;
          cmd.exec = 1'b1;
        end
        ACT_CHANGE: begin
          cmd.op = OP_DELETE_MATCH;
          cmd.match_prio = 1'b1;
          cmd.exec = 1'b1;
        end
        ACT_CLEAR: begin
          cmd.op = OP_CLEAR;
          cmd.exec = 1'b1;
        end
        default: ;
      endcase
    end else if (state == S_REINS) begin
      cmd.op = OP_INSERT;
      cmd.use_new = 1'b1;
      cmd.exec = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      iter_valid <= 1'b0;
      iter_pos <= '0;
      act <= '0;
      status <= ST_OK;
      found <= 1'b0;
      kout <= '0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            act <= req.action;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= ST_OK;
          found <= 1'b0;
          kout <= '0;
          state <= S_RESP;
          case (act)
            ACT_INSERT: begin
              iter_valid <= 1'b0;
              if (stat.is_full) status <= ST_FULL;
            end
            ACT_POP: iter_valid <= 1'b0;
            ACT_REMOVE: begin
              iter_valid <= 1'b0;
              if (stat.is_empty) status <= ST_EMPTY;
              else if (!stat.key_hit) status <= ST_NOT_FOUND;
            end
            ACT_CHANGE: begin
              iter_valid <= 1'b0;
              if (!stat.both_hit) status <= ST_NOT_FOUND;
              else state <= S_REINS;
            end
            ACT_CONTAINS: found <= stat.key_hit;
            ACT_FIRST: begin
              if (stat.is_empty) begin
                iter_valid <= 1'b0;
                status <= ST_EMPTY;
              end else begin
                iter_pos <= '0;
                iter_valid <= 1'b1;
                found <= 1'b1;
                kout <= rd_key;
              end
            end
            ACT_NEXT: begin
              if (!iter_valid || (CW'(iter_pos) + CW'(1) >= fill)) begin
                status <= ST_NOT_FOUND;
              end else begin
                iter_pos <= iter_pos + IW'(1);
                found <= 1'b1;
                kout <= rd_key;
              end
            end
            ACT_CLEAR: iter_valid <= 1'b0;
            default: ;
          endcase
        end
        S_REINS: state <= S_RESP;
        S_RESP: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue holding up to CAPACITY (key, priority) entries in descending
// priority order, stable among equals. One request is taken at a time: after the request
// transfer the controller steps through S_EXEC (and S_REINS for change priority, which
// removes then reinserts through the shared shift array) and S_RESP, then raises response
// valid. The response is held until transferred and the next request is taken in the
// cycle after that. Every compare and shift of the entry array happens in parallel in
// the same cycle. No clearing pass follows reset.
module sorted_priority_queue_core #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [IW-1:0]       rd_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic [CW-1:0]       fill;

  spq_ctrl #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_ctrl (
    .clk, .rst, .req, .rsp, .cmd, .stat, .rd_idx, .rd_key, .fill
  );

  spq_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .PRIO_BITS(PRIO_BITS)) u_dp (
    .clk, .rst, .cmd,
    .key_in(KEY_BITS'(req.key)),
    .prio_in(PRIO_BITS'(req.priority_req)),
    .new_prio_in(PRIO_BITS'(req.prio_update)),
    .rd_idx, .stat, .rd_key, .fill
  );
endmodule

// ===== rtl/spq_checker.sv =====
// port-level checks for the sorted priority queue
module spq_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [4:0] count,
  input logic       found,
  input logic [1:0] status
);
  import spq_pkg::*;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 5'd16) else $error("count beyond capacity");
  a_no_req_while_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken with response pending");
  a_rsp_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> status == ST_OK) else $error("found with error status");
endmodule

bind sorted_priority_queue_core spq_checker u_chk (
  .clk, .rst,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .count(rsp.count), .found(rsp.found), .status(rsp.status)
);

// ===== verif/sorted_priority_queue_core_tb.sv =====
// testbench for the sorted priority queue: random and directed requests checked against a model
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] key;
    logic [15:0] prio;
    logic [15:0] new_prio;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] key_out;
    logic [4:0]  count;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue_core dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #2 clk = ~clk;

  // model state
  logic [15:0] q_keys [DEPTH];
  logic [15:0] q_prios [DEPTH];
  int          q_fill;
  int          it_pos;
  bit          it_valid;

  request_t  pending_reqs [$];
  response_t expected_rsps [$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        req_taken = 1'b0;

  task automatic report(input string what, input response_t got, input response_t want);
    $display("mismatch %s: got st=%0d f=%0d k=%h c=%0d want st=%0d f=%0d k=%h c=%0d",
      what, got.status, got.found, got.key_out, got.count,
      want.status, want.found, want.key_out, want.count);
    errors++;
  endtask

  function automatic void drop_at(input int pos);
    for (int i = pos; i + 1 < q_fill; i++) begin
      q_keys[i] = q_keys[i+1];
      q_prios[i] = q_prios[i+1];
    end
    q_fill--;
  endfunction

  function automatic void place_sorted(input logic [15:0] k, input logic [15:0] p);
    int pos;
    pos = 0;
    while (pos < q_fill && q_prios[pos] >= p) pos++;
    for (int i = q_fill; i > pos; i--) begin
      q_keys[i] = q_keys[i-1];
      q_prios[i] = q_prios[i-1];
    end
    q_keys[pos] = k;
    q_prios[pos] = p;
    q_fill++;
  endfunction

  function automatic response_t queue_result(input request_t r);
    response_t o;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_INSERT: begin
        it_valid = 0;
        if (q_fill >= DEPTH) o.status = ST_FULL;
        else place_sorted(r.key, r.prio);
      end
      ACT_POP: begin
        it_valid = 0;
        if (q_fill > 0) drop_at(0);
      end
      ACT_REMOVE: begin
        it_valid = 0;
        if (q_fill == 0) o.status = ST_EMPTY;
        else begin
          o.status = ST_NOT_FOUND;
          for (int i = 0; i < q_fill; i++) begin
            if (q_keys[i] == r.key) begin
              drop_at(i);
              o.status = ST_OK;
              break;
            end
          end
        end
      end
      ACT_CHANGE: begin
        it_valid = 0;
        o.status = ST_NOT_FOUND;
        for (int i = 0; i < q_fill; i++) begin
          if (q_keys[i] == r.key && q_prios[i] == r.prio) begin
            drop_at(i);
            place_sorted(r.key, r.new_prio);
            o.status = ST_OK;
            break;
          end
        end
      end
      ACT_CONTAINS: begin
        for (int i = 0; i < q_fill; i++)
          if (q_keys[i] == r.key) o.found = 1'b1;
      end
      ACT_FIRST: begin
        if (q_fill == 0) begin
          it_valid = 0;
          o.status = ST_EMPTY;
        end else begin
          it_pos = 0;
          it_valid = 1;
          o.found = 1'b1;
          o.key_out = q_keys[0];
        end
      end
      ACT_NEXT: begin
        if (!it_valid || it_pos + 1 >= q_fill) o.status = ST_NOT_FOUND;
        else begin
          it_pos++;
          o.found = 1'b1;
          o.key_out = q_keys[it_pos];
        end
      end
      ACT_CLEAR: begin
        q_fill = 0;
        it_valid = 0;
      end
      default: ;
    endcase
    o.count = q_fill[4:0];
    return o;
  endfunction

  function automatic request_t make_req(input logic [3:0] a, input logic [15:0] k,
                                        input logic [15:0] p, input logic [15:0] np);
    request_t r;
    r.action = a;
    r.key = k;
    r.prio = p;
    r.new_prio = np;
    return r;
  endfunction

  // small key and priority pools so matches and ties happen often
  function automatic request_t random_req();
    request_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    r.prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    r.new_prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    if (sel < 30) r.action = ACT_INSERT;
    else if (sel < 38) r.action = ACT_POP;
    else if (sel < 48) r.action = ACT_REMOVE;
    else if (sel < 60) r.action = ACT_CHANGE;
    else if (sel < 68) r.action = ACT_CONTAINS;
    else if (sel < 72) r.action = ACT_SIZE;
    else if (sel < 78) r.action = ACT_FIRST;
    else if (sel < 94) r.action = ACT_NEXT;
    else if (sel < 96) r.action = ACT_CLEAR;
    else r.action = 4'($urandom_range(9, 15));
    return r;
  endfunction

  initial begin
    q_fill = 0;
    it_pos = 0;
    it_valid = 0;
    // directed: empty cases, extremes, full queue, ties, iteration, clear
    pending_reqs.push_back(make_req(ACT_POP, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_REMOVE, 16'h1, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_FIRST, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_NEXT, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_CHANGE, 16'h1, 16'h1, 16'h2));
    for (int i = 0; i < DEPTH; i++)
      pending_reqs.push_back(make_req(ACT_INSERT, (i == 0) ? 16'hffff : 16'(i),
        (i % 3 == 0) ? 16'hffff : 16'(i % 3), 16'h0));
    pending_reqs.push_back(make_req(ACT_INSERT, 16'h5555, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_CHANGE, 16'h1, 16'h1, 16'hffff));
    pending_reqs.push_back(make_req(ACT_FIRST, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_NEXT, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_CONTAINS, 16'hffff, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_REMOVE, 16'h1234, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(ACT_SIZE, 16'h0, 16'h0, 16'h0));
    pending_reqs.push_back(make_req(4'd15, 16'hffff, 16'hffff, 16'hffff));
    pending_reqs.push_back(make_req(ACT_CLEAR, 16'h0, 16'h0, 16'h0));
    for (int i = 0; i < 750; i++) pending_reqs.push_back(random_req());
  end

  // remembers whether the request offered was transferred at the last rising edge
  always @(posedge clk) begin
    req_taken <= !rst && req.valid && req.ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.action <= '0;
      req.key <= '0;
      req.priority_req <= '0;
      req.prio_update <= '0;
    end else if (!req.valid || req_taken) begin
      // previous transfer done or nothing offered
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        request_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.action <= r.action;
        req.key <= r.key;
        req.priority_req <= r.prio;
        req.prio_update <= r.new_prio;
        if (!calm && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // sink ready
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      rsp.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      recv_gap <= $urandom_range(0, 9);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        expected_rsps.push_back(queue_result(make_req(req.action, req.key,
          req.priority_req, req.prio_update)));
      if (rsp.valid && rsp.ready) begin
        response_t got;
        response_t want;
        got.status = rsp.status;
        got.found = rsp.found;
        got.key_out = rsp.key_out;
        got.count = rsp.count;
        if (expected_rsps.size() == 0) begin
          report("unexpected response", got, '0);
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status) report("status", got, want);
          if (got.found !== want.found) report("found", got, want);
          if (got.key_out !== want.key_out) report("key_out", got, want);
          if (got.count !== want.count) report("count", got, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    calm = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_reqs.size() < 100);
    calm = 1;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (req.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
